FILE: rtl/sgc_pkg.sv
package sgc_pkg;

    localparam int CH_W        = 5;
    localparam int PROB_W      = 24;
    localparam int TOT_W       = 26;
    localparam int PAIR_W      = 25;
    localparam int RND_W       = 24;
    localparam int GATE_W      = 3;
    localparam int CNT_W       = 6;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;
    localparam int PROD_W      = RND_W + TOT_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_I_K_CLOSED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_I_K_OPEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_J_RATES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_K_I_CLOSED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_K_I_OPEN   = 3'd4;

    localparam logic [CFG_W-1:0] RST_I_K_CLOSED = 48'd14636701607526;
    localparam logic [CFG_W-1:0] RST_I_K_OPEN   = 48'd106217400067686;
    localparam logic [CFG_W-1:0] RST_J_RATES    = 48'd463537722037;
    localparam logic [CFG_W-1:0] RST_K_I_CLOSED = 48'd8136949972;
    localparam logic [CFG_W-1:0] RST_K_I_OPEN   = 48'd59055800532;

    localparam logic [GATE_W-1:0] GATES_OPEN = 3'b110;
    localparam logic [CNT_W-1:0]  TALLY_MAX  = 6'd63;

    typedef struct packed {
        logic [CFG_W-1:0] i_k_closed;
        logic [CFG_W-1:0] i_k_open;
        logic [CFG_W-1:0] j_rates;
        logic [CFG_W-1:0] k_i_closed;
        logic [CFG_W-1:0] k_i_open;
    } t_rates;

    typedef struct packed {
        logic              en;
        logic [CH_W-1:0]   ch;
        logic [GATE_W-1:0] gates;
    } t_store_wr;

endpackage

FILE: rtl/sgc_cfg_regs.sv
module sgc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sgc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sgc_pkg::CFG_W-1:0]     i_cfg_data,
    output sgc_pkg::t_rates              o_rates
);
    import sgc_pkg::*;

    t_rates r_rates;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rates.i_k_closed <= RST_I_K_CLOSED;
            r_rates.i_k_open   <= RST_I_K_OPEN;
            r_rates.j_rates    <= RST_J_RATES;
            r_rates.k_i_closed <= RST_K_I_CLOSED;
            r_rates.k_i_open   <= RST_K_I_OPEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_I_K_CLOSED: r_rates.i_k_closed <= i_cfg_data;
                REG_I_K_OPEN:   r_rates.i_k_open   <= i_cfg_data;
                REG_J_RATES:    r_rates.j_rates    <= i_cfg_data;
                REG_K_I_CLOSED: r_rates.k_i_closed <= i_cfg_data;
                REG_K_I_OPEN:   r_rates.k_i_open   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_rates = r_rates;

endmodule

FILE: rtl/sgc_gate_store.sv
module sgc_gate_store #(
    parameter int DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [sgc_pkg::CH_W-1:0]      i_rd_ch,
    input  sgc_pkg::t_store_wr            i_wr,
    output logic [sgc_pkg::GATE_W-1:0]    o_rd_gates
);
    import sgc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [GATE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [GATE_W-1:0] r_rd_data;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_addr;
    logic              r_lw_vld;
    logic [AW-1:0]     r_lw_addr;
    logic [GATE_W-1:0] r_lw_gates;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;

    assign rd_addr = i_rd_ch[AW-1:0];
    assign wr_addr = i_wr.ch[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[wr_addr] <= i_wr.gates;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
        if (i_wr.en) begin
            r_lw_addr  <= wr_addr;
            r_lw_gates <= i_wr.gates;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_lw_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[wr_addr] <= 1'b1;
                r_lw_vld       <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    // last write wins over the array copy, which misses a write on the read edge
    always_comb begin
        if (r_lw_vld && (r_lw_addr == r_rd_addr)) begin
            o_rd_gates = r_lw_gates;
        end else if (r_rd_vld) begin
            o_rd_gates = r_rd_data;
        end else begin
            o_rd_gates = '0;
        end
    end

endmodule

FILE: rtl/stochastic_gated_channel_step_unit.sv
// pipeline: a request accepted into s1 moves through s2 to the output register
// throughput: one request per cycle unless the output stalls; a request on the
//   channel just ahead waits till it leaves s2, set by the gate store RMW loop
// reset (synchronous, active low): gate store reads all zero, tally zero,
//   rates to their defaults, no result pending; no clearing pass
module stochastic_gated_channel_step_unit #(
    parameter int CHANNEL_COUNT = 32,
    parameter int FRACTION_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // channel, rnd_event, rnd_choice, zero fill
    input  logic [sgc_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // channel_out, gates, is_open, open_count, zero fill
    output logic [sgc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tlast,
    input  logic                               i_cfg_we,
    input  logic [sgc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sgc_pkg::CFG_W-1:0]          i_cfg_data
);
    import sgc_pkg::*;

    localparam int DEPTH = (CHANNEL_COUNT < 32) ? CHANNEL_COUNT : 32;
    localparam int CW    = (PAIR_W + FRACTION_BITS > PROD_W) ? PAIR_W + FRACTION_BITS : PROD_W;
    localparam logic [12:0] CH_LIMIT = 13'(CHANNEL_COUNT);

    t_rates    rates;
    t_store_wr store_wr;
    logic [GATE_W-1:0] rd_gates;

    logic [CH_W-1:0]  in_ch;
    logic [RND_W-1:0] in_ev;
    logic [RND_W-1:0] in_rc;
    logic             in_inr;

    // s1: gates arrive from the store
    logic             r_s1_v;
    logic [CH_W-1:0]  r_s1_ch;
    logic [RND_W-1:0] r_s1_ev;
    logic [RND_W-1:0] r_s1_rc;
    logic             r_s1_last;
    logic             r_s1_inr;

    // s2: decision and write back
    logic              r_s2_v;
    logic [CH_W-1:0]   r_s2_ch;
    logic [GATE_W-1:0] r_s2_g;
    logic [PROB_W-1:0] r_s2_pi;
    logic [PAIR_W-1:0] r_s2_pij;
    logic [PROD_W-1:0] r_s2_prod;
    logic              r_s2_ev;
    logic              r_s2_last;
    logic              r_s2_inr;

    logic              r_out_v;
    logic [CH_W-1:0]   r_out_ch;
    logic [GATE_W-1:0] r_out_g;
    logic              r_out_open;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;

    logic [CNT_W-1:0] r_tally;
    logic [CNT_W-1:0] n_tally;

    logic out_free, s2_go, s2_free, hazard, s1_go, s1_free, acc;

    logic [GATE_W-1:0] s1_g;
    logic [CFG_W-1:0]  reg_i, reg_k;
    logic [PROB_W-1:0] pi, pj, pk;
    logic [TOT_W-1:0]  total;
    logic              s1_ev;
    logic [PROD_W-1:0] s1_prod;
    logic [PAIR_W-1:0] s1_pij;

    logic [CW-1:0]     thr_i, thr_ij, scaled;
    logic [GATE_W-1:0] flip_g, new_g;
    logic              new_open;
    logic [CNT_W-1:0]  cnt;

    assign in_ch  = i_s_tdata[4:0];
    assign in_ev  = i_s_tdata[28:5];
    assign in_rc  = i_s_tdata[52:29];
    assign in_inr = ({8'd0, in_ch} < CH_LIMIT);

    // handshake and pipeline advance
    assign out_free = !r_out_v || i_m_tready;
    assign s2_go    = r_s2_v && out_free;
    assign s2_free  = !r_s2_v || s2_go;
    // same channel right behind: wait until its write lands in the store
    assign hazard   = r_s1_v && r_s2_v && r_s1_inr && r_s2_inr && (r_s1_ch == r_s2_ch);
    assign s1_go    = r_s1_v && s2_free && !hazard;
    assign s1_free  = !r_s1_v || s1_go;
    assign acc      = i_s_tvalid && s1_free;
    assign o_s_tready = s1_free;

    sgc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rates    (rates)
    );

    assign store_wr.en    = s2_go && r_s2_inr;
    assign store_wr.ch    = r_s2_ch;
    assign store_wr.gates = new_g;

    sgc_gate_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (acc && in_inr),
        .i_rd_ch    (in_ch),
        .i_wr       (store_wr),
        .o_rd_gates (rd_gates)
    );

    // s1 arithmetic: flip probabilities, total, scaled choice
    always_comb begin
        s1_g    = r_s1_inr ? rd_gates : '0;
        reg_i   = s1_g[0] ? rates.i_k_open : rates.i_k_closed;
        reg_k   = s1_g[2] ? rates.k_i_open : rates.k_i_closed;
        pi      = s1_g[2] ? reg_i[47:24] : reg_i[23:0];
        pj      = s1_g[1] ? rates.j_rates[47:24] : rates.j_rates[23:0];
        pk      = s1_g[0] ? reg_k[47:24] : reg_k[23:0];
        total   = TOT_W'(pi) + TOT_W'(pj) + TOT_W'(pk);
        s1_ev   = (TOT_W'(r_s1_ev) < total);
        s1_prod = PROD_W'(r_s1_rc) * PROD_W'(total);
        s1_pij  = PAIR_W'(pi) + PAIR_W'(pj);
    end

    // s2 decision and tally
    always_comb begin
        thr_i  = CW'(r_s2_pi) << FRACTION_BITS;
        thr_ij = CW'(r_s2_pij) << FRACTION_BITS;
        scaled = CW'(r_s2_prod);
        if (!r_s2_ev) begin
            flip_g = r_s2_g;
        end else if (scaled < thr_i) begin
            flip_g = r_s2_g ^ 3'b100;
        end else if (scaled < thr_ij) begin
            flip_g = r_s2_g ^ 3'b010;
        end else begin
            flip_g = r_s2_g ^ 3'b001;
        end
        new_g    = r_s2_inr ? flip_g : '0;
        new_open = r_s2_inr && (new_g == GATES_OPEN);
        cnt      = (new_open && (r_tally != TALLY_MAX)) ? r_tally + 6'd1 : r_tally;
        n_tally  = r_s2_last ? '0 : cnt;
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_ch   <= in_ch;
            r_s1_ev   <= in_ev;
            r_s1_rc   <= in_rc;
            r_s1_last <= i_s_tlast;
            r_s1_inr  <= in_inr;
        end
        if (s1_go) begin
            r_s2_ch   <= r_s1_ch;
            r_s2_g    <= s1_g;
            r_s2_pi   <= pi;
            r_s2_pij  <= s1_pij;
            r_s2_prod <= s1_prod;
            r_s2_ev   <= s1_ev;
            r_s2_last <= r_s1_last;
            r_s2_inr  <= r_s1_inr;
        end
        if (s2_go) begin
            r_out_ch   <= r_s2_ch;
            r_out_g    <= new_g;
            r_out_open <= new_open;
            r_out_cnt  <= cnt;
            r_out_last <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_tally <= '0;
        end else begin
            r_s1_v  <= acc || (r_s1_v && !s1_go);
            r_s2_v  <= s1_go || (r_s2_v && !s2_go);
            r_out_v <= s2_go || (r_out_v && !i_m_tready);
            if (s2_go) begin
                r_tally <= n_tally;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {1'b0, r_out_cnt, r_out_open, r_out_g, r_out_ch};
    assign o_m_tlast  = r_out_last;

endmodule

FILE: rtl/sgc_checker.sv
module sgc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [sgc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                            o_m_tlast
);
    import sgc_pkg::*;

    logic r_after_last;

    // set at reset and by a tick-closing result going out, cleared by any other
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b1;
        end else if (o_m_tvalid && i_m_tready) begin
            r_after_last <= o_m_tlast;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_open_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[8] == (o_m_tdata[7:5] == GATES_OPEN)))
        else $error("open flag disagrees with gates");

    a_open_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> (o_m_tdata[14:9] != 6'd0))
        else $error("open channel not counted");

    a_tick_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_after_last |-> (o_m_tdata[14:9] <= 6'd1))
        else $error("tally not cleared at tick end");

endmodule

bind stochastic_gated_channel_step_unit sgc_checker u_sgc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
